// ----- design/upap_pkg.sv -----
// shared types and constants of the username/password authentication parser
`default_nettype none
package upap_pkg;

	// number of credential bytes held per register
	localparam int unsigned MAX_CRED_BYTES = 8;

	// configuration port geometry
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_ADDR_W = 5;

	// register indexes
	typedef enum logic [1:0] {
		REG_USER     = 2'd0,
		REG_USER_LEN = 2'd1,
		REG_PASS     = 2'd2,
		REG_PASS_LEN = 2'd3
	} reg_idx_t;

	// reset credentials: "admin", first byte lowest
	localparam logic [63:0] CRED_RESET = 64'h0000_006E_696D_6461;
	localparam logic [3:0]  LEN_RESET  = 4'd5;

	localparam logic [7:0] AUTH_VER_BYTE = 8'h01;

	typedef enum logic [2:0] {
		PH_VER  = 3'd0,
		PH_ULEN = 3'd1,
		PH_USER = 3'd2,
		PH_PLEN = 3'd3,
		PH_PASS = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_MORE      = 2'd0,
		ST_OK        = 2'd1,
		ST_REFUSED   = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ----- design/userpass_auth_parser.sv -----
// top level of the username/password authentication request parser
`default_nettype none
// Byte-serial checker for a username/password authentication request laid out as
// VER(=1) ULEN UNAME[ULEN] PLEN PASSWD[PLEN]. Each accepted input word carries one
// request byte and produces exactly one result word: status (0 need more, 1 accepted,
// 2 refused, 3 malformed) and stage, the phase after that byte. The name and password
// are compared on the fly against the credentials in the configuration registers
// (reset value "admin" for both, length 5); nothing of the received credentials is
// kept. A bad version byte or a zero length gives malformed; a length that differs
// from the register length refuses at the last password byte. After any final result
// the parser waits for a new version byte. Throughput is one word per clock cycle
// while the output side does not stall, set by the combinational phase/byte-count
// update. The byte lands in the input register when it is accepted, and its result
// then moves into the result register, which drives out_valid; the result is taken
// while out_stall is low. The input is stalled only while both the input and
// the result register hold a word and the output side stalls.
// Credential registers sit at byte addresses 0, 8, 16 and 24 with 64-bit data.
module userpass_auth_parser #(
	parameter int unsigned MAX_CRED_BYTES = upap_pkg::MAX_CRED_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [upap_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [upap_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [upap_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready,
	// request byte stream
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      data_byte,
	// result stream
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [1:0]                      status,
	output logic      [2:0]                      stage
);
	import upap_pkg::*;

	localparam int unsigned CW = 8 * MAX_CRED_BYTES;

	// expected credentials from the register file
	logic [CW-1:0] exp_user;
	logic [CW-1:0] exp_pass;
	logic [3:0]    exp_user_len;
	logic [3:0]    exp_pass_len;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;

	// parser state
	phase_t     phase_q;
	logic [7:0] bytes_left_q;
	logic [7:0] field_len_q;
	logic       matching_q;

	// result register
	logic       out_valid_q;
	status_t    status_q;
	phase_t     stage_q;

	// next-state values
	phase_t     phase_d;
	logic [7:0] bytes_left_d;
	logic [7:0] field_len_d;
	logic       matching_d;
	status_t    status_d;

	// byte compare helpers
	logic [CW-1:0] cred_sel;
	logic [7:0]    byte_idx;
	logic [7:0]    bytes_left_dec;
	logic          byte_ok;
	logic          len_ok;

	logic advance;

	upap_regs #(
		.MAX_CRED_BYTES(MAX_CRED_BYTES)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.exp_user     (exp_user),
		.exp_user_len (exp_user_len),
		.exp_pass     (exp_pass),
		.exp_pass_len (exp_pass_len)
	);

	assign pready = 1'b1;

	// the result register frees up when it is empty or being taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	// input register moves whenever the word it holds can go on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	// position of this byte inside its field
	assign byte_idx       = field_len_q - bytes_left_q;
	assign bytes_left_dec = bytes_left_q - 8'd1;
	assign cred_sel       = (phase_q == PH_USER) ? exp_user : exp_pass;
	assign len_ok         = (data_s1 ==
		{4'd0, ((phase_q == PH_ULEN) ? exp_user_len : exp_pass_len)});

	// byte lanes: positions at or beyond the register width never match
	always_comb begin
		byte_ok = 1'b0;
		for (int i = 0; i < MAX_CRED_BYTES; i++) begin
			if (byte_idx == 8'(i) && cred_sel[8*i +: 8] == data_s1) begin
				byte_ok = 1'b1;
			end
		end
	end

	// per-byte phase update
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		field_len_d  = field_len_q;
		matching_d   = matching_q;
		status_d     = ST_MORE;
		unique case (phase_q)
			PH_ULEN, PH_PLEN: begin
				if (data_s1 == 8'd0) begin
					// zero length is malformed
					status_d     = ST_MALFORMED;
					phase_d      = PH_VER;
					bytes_left_d = 8'd0;
					field_len_d  = 8'd0;
					matching_d   = 1'b1;
				end else begin
					field_len_d  = data_s1;
					bytes_left_d = data_s1;
					if (!len_ok) begin
						matching_d = 1'b0;
					end
					phase_d = (phase_q == PH_ULEN) ? PH_USER : PH_PASS;
				end
			end
			PH_USER, PH_PASS: begin
				bytes_left_d = bytes_left_dec;
				if (!byte_ok) begin
					matching_d = 1'b0;
				end
				if (bytes_left_dec == 8'd0) begin
					if (phase_q == PH_USER) begin
						phase_d = PH_PLEN;
					end else begin
						status_d     = (matching_q && byte_ok) ? ST_OK : ST_REFUSED;
						phase_d      = PH_VER;
						bytes_left_d = 8'd0;
						field_len_d  = 8'd0;
						matching_d   = 1'b1;
					end
				end
			end
			default: begin
				// waiting for the version byte
				status_d     = (data_s1 == AUTH_VER_BYTE) ? ST_MORE : ST_MALFORMED;
				phase_d      = (data_s1 == AUTH_VER_BYTE) ? PH_ULEN : PH_VER;
				bytes_left_d = 8'd0;
				field_len_d  = 8'd0;
				matching_d   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_VER;
			bytes_left_q <= 8'd0;
			field_len_q  <= 8'd0;
			matching_q   <= 1'b1;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q      <= phase_d;
				bytes_left_q <= bytes_left_d;
				field_len_q  <= field_len_d;
				matching_q   <= matching_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= status_d;
			stage_q  <= phase_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign stage     = stage_q;

	// a final verdict always leaves the parser waiting for a version byte
	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MORE |-> stage == PH_VER)
		else $error("final result without return to version phase");

	// inside a name or password field there is always at least one byte to come
	a_bytes_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_USER || phase_q == PH_PASS) |-> bytes_left_q != 8'd0)
		else $error("credential field phase with no bytes left");

	// the input is only held back by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// the result register tracks the current phase
	a_stage_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid && stage == phase_q)
		else $error("result stage disagrees with parser phase");

endmodule
`default_nettype wire

// ----- design/upap_regs.sv -----
// configuration register file holding the expected credentials
`default_nettype none
module upap_regs #(
	parameter int unsigned MAX_CRED_BYTES = upap_pkg::MAX_CRED_BYTES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [upap_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [upap_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [upap_pkg::CFG_DATA_W-1:0]     prdata,
	output logic      [8*MAX_CRED_BYTES-1:0]         exp_user,
	output logic      [3:0]                          exp_user_len,
	output logic      [8*MAX_CRED_BYTES-1:0]         exp_pass,
	output logic      [3:0]                          exp_pass_len
);
	import upap_pkg::*;

	localparam int unsigned CW = 8 * MAX_CRED_BYTES;

	reg_idx_t reg_sel;
	logic     wr_en;

	// registers sit on eight-byte boundaries
	assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_user     <= CRED_RESET[CW-1:0];
			exp_user_len <= LEN_RESET;
			exp_pass     <= CRED_RESET[CW-1:0];
			exp_pass_len <= LEN_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_USER:     exp_user     <= pwdata[CW-1:0];
				REG_USER_LEN: exp_user_len <= pwdata[3:0];
				REG_PASS:     exp_pass     <= pwdata[CW-1:0];
				REG_PASS_LEN: exp_pass_len <= pwdata[3:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_USER:     prdata = CFG_DATA_W'(exp_user);
			REG_USER_LEN: prdata = CFG_DATA_W'(exp_user_len);
			REG_PASS:     prdata = CFG_DATA_W'(exp_pass);
			REG_PASS_LEN: prdata = CFG_DATA_W'(exp_pass_len);
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for the username/password authentication request parser
`timescale 1ns / 1ps

module tb_top;
	import upap_pkg::*;

	// one expected result word
	typedef struct packed {
		status_t st;
		phase_t  stg;
	} auth_result_t;

	// receiver stall behaviour, switched after a random stretch
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_EVERY_FOURTH
	} rx_mode_t;

	localparam int WORDS_PER_SETTING = 110;
	localparam int NUM_SETTINGS      = 8;
	localparam int DRAIN_LIMIT       = 5000;

	// tracks the request parser state and holds the results still owed by the block
	class auth_scoreboard;
		logic [63:0] user_cred = CRED_RESET;
		logic [3:0]  user_len  = LEN_RESET;
		logic [63:0] pass_cred = CRED_RESET;
		logic [3:0]  pass_len  = LEN_RESET;

		phase_t     ph       = PH_VER;
		logic [7:0] left     = 8'd0;
		logic [7:0] flen     = 8'd0;
		bit         matching = 1'b1;

		auth_result_t expected_q[$];
		int unsigned  mismatches, n_checked, n_ok, n_refused, n_malformed;

		function void write_reg(reg_idx_t r, logic [63:0] v);
			case (r)
				REG_USER:     user_cred = v;
				REG_USER_LEN: user_len  = v[3:0];
				REG_PASS:     pass_cred = v;
				REG_PASS_LEN: pass_len  = v[3:0];
				default: ;
			endcase
		endfunction

		function void restart_request();
			ph       = PH_VER;
			left     = 8'd0;
			flen     = 8'd0;
			matching = 1'b1;
		endfunction

		// bytes past the credential store never match
		function bit cred_byte_ok(logic [63:0] cred, logic [7:0] idx, logic [7:0] b);
			if (idx >= MAX_CRED_BYTES)
				return 1'b0;
			return cred[8*int'(idx) +: 8] == b;
		endfunction

		function void note_byte(logic [7:0] b);
			status_t      st;
			logic [7:0]   idx;
			auth_result_t res;
			st = ST_MORE;
			case (ph)
				PH_ULEN, PH_PLEN: begin
					if (b == 8'd0) begin
						st = ST_MALFORMED;
						restart_request();
					end else begin
						flen = b;
						left = b;
						if (b != {4'd0, (ph == PH_ULEN) ? user_len : pass_len})
							matching = 1'b0;
						if (ph == PH_ULEN)
							ph = PH_USER;
						else
							ph = PH_PASS;
					end
				end
				PH_USER, PH_PASS: begin
					idx = flen - left;
					if (!cred_byte_ok((ph == PH_USER) ? user_cred : pass_cred, idx, b))
						matching = 1'b0;
					left = left - 8'd1;
					if (left == 8'd0) begin
						if (ph == PH_USER) begin
							ph = PH_PLEN;
						end else begin
							st = matching ? ST_OK : ST_REFUSED;
							restart_request();
						end
					end
				end
				default: begin
					restart_request();
					if (b != AUTH_VER_BYTE)
						st = ST_MALFORMED;
					else
						ph = PH_ULEN;
				end
			endcase
			res.st  = st;
			res.stg = ph;
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [1:0] st, logic [2:0] stg);
			auth_result_t res;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d stage %0d",
					$time, st, stg);
				mismatches++;
				return;
			end
			res = expected_q.pop_front();
			n_checked++;
			if (st !== res.st) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, res.st, st);
				mismatches++;
			end
			if (stg !== res.stg) begin
				$display("%0t: stage mismatch, expected %0d, got %0d", $time, res.stg, stg);
				mismatches++;
			end
			case (res.st)
				ST_OK:        n_ok++;
				ST_REFUSED:   n_refused++;
				ST_MALFORMED: n_malformed++;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	logic [2:0] stage;

	auth_scoreboard sb = new();

	// request under construction, one byte per entry
	logic [7:0] req_q[$];

	int       burst_left = 0;
	bit       no_gaps    = 1'b0;
	int       words_sent = 0;
	int       cfg_writes = 0;
	int       pauses     = 0;
	rx_mode_t rx_mode    = RX_FREE;
	int       rx_left    = 0;
	int       rx_cycle   = 0;

	userpass_auth_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.stage     (stage)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
		$display("** userpass_auth_parser: FAILED **");
		$finish;
	end

	// receiver: each mode lasts a random stretch, including stretches with no stall at all
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FREE:         out_stall <= 1'b0;
			RX_LIGHT:        out_stall <= ($urandom_range(0, 99) < 30);
			RX_HEAVY:        out_stall <= ($urandom_range(0, 99) < 80);
			RX_EVERY_FOURTH: out_stall <= (rx_cycle % 4 == 0);
			default:         out_stall <= 1'b0;
		endcase
	end

	// both handshakes are sampled at the edge, before any of this step's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(data_byte);
			if (out_valid && !out_stall)
				sb.check_result(status, stage);
		end
	end

	// two-phase register write; returns only after the bus is left idle, so back-to-back calls are clean
	task automatic cfg_write(input reg_idx_t r, input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(r, v);
		cfg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// offer one word, with the sender going quiet between bursts of random length
	task automatic put_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = no_gaps ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_request();
		foreach (req_q[i])
			put_byte(req_q[i]);
		req_q.delete();
	endtask

	// hold the sender until every owed result has come back, then let the pipe settle
	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		pauses++;
	endtask

	// length byte then body; each body byte inside the credential store is taken from the credential with the given odds
	task automatic append_field(input int len, input logic [63:0] cred, input int exact_pct);
		logic [7:0] b;
		req_q.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			if (i < MAX_CRED_BYTES && $urandom_range(0, 99) < exact_pct)
				b = cred[8*i +: 8];
			else
				b = 8'($urandom_range(0, 255));
			req_q.push_back(b);
		end
	endtask

	function automatic int pick_len(input logic [3:0] reg_len, input bit follow_reg);
		if (follow_reg)
			return (reg_len == 4'd0) ? $urandom_range(1, 8) : int'(reg_len);
		// very occasionally the longest field the length byte allows
		if ($urandom_range(0, 99) == 0)
			return 255;
		return $urandom_range(1, 10);
	endfunction

	task automatic build_request();
		int  kind, pct;
		bit  follow;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// line noise
			repeat ($urandom_range(1, 4))
				req_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 14) begin
			// wrong version byte
			req_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(2, 255)));
		end else if (kind < 20) begin
			// zero user or password length
			req_q.push_back(AUTH_VER_BYTE);
			if ($urandom_range(0, 1))
				append_field($urandom_range(1, 4), sb.user_cred, 50);
			req_q.push_back(8'h00);
		end else if (kind < 24) begin
			// request cut short, the next one lands mid-field
			req_q.push_back(AUTH_VER_BYTE);
			append_field(pick_len(sb.user_len, 1'b1), sb.user_cred, 100);
			repeat (2) void'(req_q.pop_back());
		end else begin
			// well-formed, mostly with the configured credentials
			follow = (kind < 75);
			pct = follow ? (($urandom_range(0, 3) == 0) ? 90 : 100) : 50;
			req_q.push_back(AUTH_VER_BYTE);
			append_field(pick_len(sb.user_len, follow), sb.user_cred, pct);
			append_field(pick_len(sb.pass_len, follow), sb.pass_cred, pct);
		end
	endtask

	// one register setting per pass; the early ones cover the corners
	task automatic load_setting(input int p);
		logic [63:0] u, pw;
		logic [3:0]  ul, pl;
		u  = {$urandom, $urandom};
		pw = {$urandom, $urandom};
		ul = 4'($urandom_range(1, 8));
		pl = 4'($urandom_range(1, 8));
		case (p)
			1: begin u = '1; pw = '1; ul = 4'd8; pl = 4'd8; end
			2: begin u = '0; pw = '0; ul = 4'd1; pl = 4'd1; end
			// zero length and lengths past the store can never be accepted
			3: begin ul = 4'd0; pl = 4'd15; end
			4: ul = 4'd9;
			default: ;
		endcase
		// upper bits of the length writes are junk the block must drop
		cfg_write(REG_USER, u);
		cfg_write(REG_USER_LEN, {$urandom, 28'($urandom), ul});
		cfg_write(REG_PASS, pw);
		cfg_write(REG_PASS_LEN, {$urandom, 28'($urandom), pl});
	endtask

	initial begin
		int start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad versions, zero user length, the reset credentials accepted,
		// zero password length, user length differing from the register
		req_q = '{8'hFF, 8'h00, AUTH_VER_BYTE, 8'h00, AUTH_VER_BYTE};
		append_field(5, CRED_RESET, 100);
		append_field(5, CRED_RESET, 100);
		req_q.push_back(AUTH_VER_BYTE);
		append_field(1, CRED_RESET, 100);
		req_q.push_back(8'h00);
		req_q.push_back(AUTH_VER_BYTE);
		append_field(1, CRED_RESET, 100);
		append_field(1, CRED_RESET, 100);
		send_request();
		drain_results();

		// random: the first pass runs on the reset credentials
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			if (p > 0)
				load_setting(p);
			no_gaps = ($urandom_range(0, 3) == 0);
			start = words_sent;
			while (words_sent - start < WORDS_PER_SETTING) begin
				build_request();
				send_request();
				if ($urandom_range(0, 99) < 3)
					drain_results();
			end
			drain_results();
		end

		$display("sent %0d request words over %0d register settings (%0d register writes)",
			words_sent, NUM_SETTINGS, cfg_writes);
		$display("checked %0d results: %0d accepted, %0d refused, %0d malformed, %0d pauses",
			sb.n_checked, sb.n_ok, sb.n_refused, sb.n_malformed, pauses);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** userpass_auth_parser: PASSED **");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d expected results never arrived", $time, sb.pending());
			$display("** userpass_auth_parser: FAILED **");
		end
		$finish;
	end

endmodule
